// File: rtl/core/lppg_pkg.sv
// shared types, constants and tables of the lens profile point generator
`default_nettype none
package lppg_pkg;

   // trig values and angles are Q2.30
   localparam int unsigned TrigBits = 30;
   localparam logic [30:0] HALFPI_Q = 31'd1686629713;
   localparam logic [30:0] ONE_Q = 31'h4000_0000;
   localparam logic [63:0] RND_Q = 64'h2000_0000;

   // serial unit operations
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   typedef struct packed {
      logic        start;
      logic        op;
      logic [63:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;

   typedef struct packed {
      logic [24:0] point_x;
      logic [24:0] point_z;
      logic        is_plane;
      logic        last_point;
   } point_type;

   // divisor of the k-th taylor term: (2k)(2k+1) for sin, (2k-1)(2k) for cos
   function automatic logic [8:0] taylor_divisor(input logic [3:0] k, input logic is_cos);
      logic [8:0] dv;
      dv = 9'd1;
      if (is_cos) begin
         case (k)
            4'd1: dv = 9'd2;
            4'd2: dv = 9'd12;
            4'd3: dv = 9'd30;
            4'd4: dv = 9'd56;
            4'd5: dv = 9'd90;
            4'd6: dv = 9'd132;
            4'd7: dv = 9'd182;
            4'd8: dv = 9'd240;
            default: dv = 9'd1;
         endcase
      end else begin
         case (k)
            4'd1: dv = 9'd6;
            4'd2: dv = 9'd20;
            4'd3: dv = 9'd42;
            4'd4: dv = 9'd72;
            4'd5: dv = 9'd110;
            4'd6: dv = 9'd156;
            4'd7: dv = 9'd210;
            default: dv = 9'd1;
         endcase
      end
      return dv;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/lppg_serial_alu.sv
// bit-serial multiplier (32x32) and restoring divider (64/32) sharing one datapath
`default_nettype none
module lppg_serial_alu (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lppg_pkg::alu_req_type req,
   output lppg_pkg::alu_rsp_type      rsp
);
   import lppg_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        op_ff, op_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] opd_ff, opd_in;
   logic [32:0] hi_ff, hi_in;
   logic [63:0] lo_ff, lo_in;

   logic [32:0] madd_w;
   logic [32:0] rem_w;
   logic        ge_w;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      opd_ff <= opd_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   // one multiplier bit or one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      opd_in  = opd_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      madd_w  = {1'b0, hi_ff[31:0]} + (lo_ff[0] ? {1'b0, opd_ff} : 33'd0);
      rem_w   = {hi_ff[31:0], lo_ff[63]};
      ge_w    = rem_w >= {1'b0, opd_ff};
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         hi_in   = 33'd0;
         if (req.op == OP_MUL) begin
            cnt_in = 6'd31;
            opd_in = req.a[31:0];
            lo_in  = {32'd0, req.b};
         end else begin
            cnt_in = 6'd63;
            opd_in = req.b;
            lo_in  = req.a;
         end
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            hi_in = {1'b0, madd_w[32:1]};
            lo_in = {32'd0, madd_w[0], lo_ff[31:1]};
         end else begin
            hi_in = ge_w ? (rem_w - {1'b0, opd_ff}) : rem_w;
            lo_in = {lo_ff[62:0], ge_w};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = (op_ff == OP_MUL) ? {hi_ff[31:0], lo_ff[31:0]} : lo_ff;

endmodule
`default_nettype wire

// File: rtl/core/lppg_seq.sv
// sequencer: plane test, asin search, taylor sin/cos and point scaling
`default_nettype none
module lppg_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [23:0]          diameter,
   input  wire logic [23:0]          radius,
   input  wire logic [6:0]           stack_count,
   output logic                      idle,
   output lppg_pkg::alu_req_type      alu_req,
   input  wire lppg_pkg::alu_rsp_type alu_rsp,
   output lppg_pkg::point_type        pt,
   output logic                      pt_valid,
   input  wire logic                 pt_ready
);
   import lppg_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PL_MUL   = 4'd1;
   localparam logic [3:0] S_PL_DIV   = 4'd2;
   localparam logic [3:0] S_S_DIV    = 4'd3;
   localparam logic [3:0] S_AS_CAND  = 4'd4;
   localparam logic [3:0] S_AS_CHK   = 4'd5;
   localparam logic [3:0] S_ANG_MUL  = 4'd6;
   localparam logic [3:0] S_ANG_DIV  = 4'd7;
   localparam logic [3:0] S_COS_DONE = 4'd8;
   localparam logic [3:0] S_SC_X     = 4'd9;
   localparam logic [3:0] S_SC_Z     = 4'd10;
   localparam logic [3:0] S_EMIT     = 4'd11;
   localparam logic [3:0] S_TRIG_SQ  = 4'd12;
   localparam logic [3:0] S_TRIG_MUL = 4'd13;
   localparam logic [3:0] S_TRIG_DIV = 4'd14;

   logic [3:0]         state_ff, state_in;
   logic [3:0]         ret_ff, ret_in;
   logic               wait_ff, wait_in;
   logic [23:0]        d_ff, d_in;
   logic [23:0]        rabs_ff, rabs_in;
   logic               neg_ff, neg_in;
   logic               plane_ff, plane_in;
   logic [6:0]         stacks_ff, stacks_in;
   logic [5:0]         half_ff, half_in;
   logic [5:0]         i_ff, i_in;
   logic [30:0]        s_ff, s_in;
   logic [30:0]        h_ff, h_in;
   logic [4:0]         bit_ff, bit_in;
   logic [30:0]        tx_ff, tx_in;
   logic               cos_mode_ff, cos_mode_in;
   logic [31:0]        x2_ff, x2_in;
   logic [31:0]        term_ff, term_in;
   logic signed [35:0] sum_ff, sum_in;
   logic [3:0]         k_ff, k_in;
   logic signed [35:0] cval_ff, cval_in;
   logic signed [27:0] xval_ff, xval_in;
   logic [63:0]        tmp_ff, tmp_in;
   point_type          pt_ff, pt_in;

   logic               uses_alu_w;
   logic [30:0]        cand_w;
   logic [63:0]        rnd_w;
   logic [25:0]        p_w;
   logic signed [35:0] smag_src_w;
   logic [35:0]        smag_w;
   logic [7:0]         diff_w;
   logic [23:0]        rabs_w;
   logic [6:0]         stacks_w;
   logic signed [35:0] q_signed_w;
   logic signed [27:0] zs_w;
   logic signed [27:0] z_w;
   logic [3:0]         k_last_w;

   function automatic logic [24:0] sat25(input logic signed [27:0] v);
      logic [24:0] r;
      if (v > 28'sd16777215) r = 25'h0FF_FFFF;
      else if (v < -28'sd16777216) r = 25'h100_0000;
      else r = v[24:0];
      return r;
   endfunction

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      d_ff        <= d_in;
      rabs_ff     <= rabs_in;
      neg_ff      <= neg_in;
      plane_ff    <= plane_in;
      stacks_ff   <= stacks_in;
      half_ff     <= half_in;
      i_ff        <= i_in;
      s_ff        <= s_in;
      h_ff        <= h_in;
      bit_ff      <= bit_in;
      tx_ff       <= tx_in;
      cos_mode_ff <= cos_mode_in;
      x2_ff       <= x2_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      k_ff        <= k_in;
      cval_ff     <= cval_in;
      xval_ff     <= xval_in;
      tmp_ff      <= tmp_in;
      pt_ff       <= pt_in;
   end

   // operands of the serial unit for each state
   always_comb begin
      smag_src_w = (state_ff == S_SC_X) ? cval_ff : sum_ff;
      smag_w     = smag_src_w[35] ? 36'(-smag_src_w) : 36'(smag_src_w);
      diff_w     = {1'b0, stacks_ff} - {1'b0, i_ff, 1'b0};
      alu_req.op = OP_MUL;
      alu_req.a  = 64'd0;
      alu_req.b  = 32'd0;
      uses_alu_w = 1'b1;
      case (state_ff)
         S_PL_MUL: begin
            alu_req.a = {40'd0, d_ff};
            alu_req.b = {24'd0, diff_w};
         end
         S_PL_DIV: begin
            alu_req.op = OP_DIV;
            alu_req.a  = tmp_ff;
            alu_req.b  = {24'd0, stacks_ff, 1'b0};
         end
         S_S_DIV: begin
            alu_req.op = OP_DIV;
            alu_req.a  = {10'd0, d_ff, 30'd0};
            alu_req.b  = {7'd0, rabs_ff, 1'b0};
         end
         S_ANG_MUL: begin
            alu_req.a = {58'd0, i_ff + 6'd1};
            alu_req.b = {1'b0, h_ff};
         end
         S_ANG_DIV: begin
            alu_req.op = OP_DIV;
            alu_req.a  = tmp_ff;
            alu_req.b  = {26'd0, half_ff};
         end
         S_SC_X, S_SC_Z: begin
            alu_req.a = {40'd0, rabs_ff};
            alu_req.b = smag_w[31:0];
         end
         S_TRIG_SQ: begin
            alu_req.a = {33'd0, tx_ff};
            alu_req.b = {1'b0, tx_ff};
         end
         S_TRIG_MUL: begin
            alu_req.a = {32'd0, term_ff};
            alu_req.b = x2_ff;
         end
         S_TRIG_DIV: begin
            alu_req.op = OP_DIV;
            alu_req.a  = tmp_ff;
            alu_req.b  = {23'd0, taylor_divisor(k_ff, cos_mode_ff)};
         end
         default: uses_alu_w = 1'b0;
      endcase
      alu_req.start = uses_alu_w && !wait_ff;
   end

   // sequencing
   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      wait_in     = wait_ff;
      d_in        = d_ff;
      rabs_in     = rabs_ff;
      neg_in      = neg_ff;
      plane_in    = plane_ff;
      stacks_in   = stacks_ff;
      half_in     = half_ff;
      i_in        = i_ff;
      s_in        = s_ff;
      h_in        = h_ff;
      bit_in      = bit_ff;
      tx_in       = tx_ff;
      cos_mode_in = cos_mode_ff;
      x2_in       = x2_ff;
      term_in     = term_ff;
      sum_in      = sum_ff;
      k_in        = k_ff;
      cval_in     = cval_ff;
      xval_in     = xval_ff;
      tmp_in      = tmp_ff;
      pt_in       = pt_ff;

      cand_w     = h_ff | (31'd1 << bit_ff);
      rnd_w      = alu_rsp.result + RND_Q;
      p_w        = rnd_w[55:30];
      rabs_w     = radius[23] ? (24'd0 - radius) : radius;
      stacks_w   = (stack_count < 7'd2) ? 7'd2 : stack_count;
      q_signed_w = $signed({4'd0, alu_rsp.result[31:0]});
      zs_w       = (sum_ff[35] ? -$signed({2'b0, p_w}) : $signed({2'b0, p_w}))
                   - $signed({4'b0, rabs_ff});
      z_w        = neg_ff ? -zs_w : zs_w;
      k_last_w   = cos_mode_ff ? 4'd8 : 4'd7;

      if (uses_alu_w && !wait_ff) wait_in = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               d_in      = diameter;
               rabs_in   = rabs_w;
               neg_in    = radius[23];
               stacks_in = stacks_w;
               half_in   = stacks_w[6:1];
               i_in      = 6'd0;
               plane_in  = (radius == 24'd0) || ({rabs_w, 1'b0} < {1'b0, diameter});
               state_in  = plane_in ? S_PL_MUL : S_S_DIV;
            end
         end

         // flat surface: x = (d*(stacks-2i) + stacks) / (2*stacks)
         S_PL_MUL: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in  = 1'b0;
               tmp_in   = alu_rsp.result + {57'd0, stacks_ff};
               state_in = S_PL_DIV;
            end
         end
         S_PL_DIV: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in           = 1'b0;
               pt_in.point_x     = alu_rsp.result[24:0];
               pt_in.point_z     = 25'd0;
               pt_in.is_plane    = 1'b1;
               pt_in.last_point  = (i_ff == half_ff);
               state_in          = S_EMIT;
            end
         end

         // sine of the half aperture, clamped to one
         S_S_DIV: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in  = 1'b0;
               s_in     = (alu_rsp.result > {33'd0, ONE_Q}) ? ONE_Q : alu_rsp.result[30:0];
               h_in     = 31'd0;
               bit_in   = 5'd30;
               state_in = S_AS_CAND;
            end
         end

         // asin by bit search, one candidate bit per sin evaluation
         S_AS_CAND: begin
            if (cand_w <= HALFPI_Q) begin
               tx_in       = cand_w;
               cos_mode_in = 1'b0;
               ret_in      = S_AS_CHK;
               state_in    = S_TRIG_SQ;
            end else if (bit_ff == 5'd0) begin
               i_in     = 6'd0;
               state_in = S_ANG_MUL;
            end else begin
               bit_in   = bit_ff - 5'd1;
               state_in = S_AS_CAND;
            end
         end
         S_AS_CHK: begin
            if (sum_ff <= $signed({5'd0, s_ff})) h_in = tx_ff;
            if (bit_ff == 5'd0) begin
               i_in     = 6'd0;
               state_in = S_ANG_MUL;
            end else begin
               bit_in   = bit_ff - 5'd1;
               state_in = S_AS_CAND;
            end
         end

         // point angle: halfpi - h + (i+1)*h/half
         S_ANG_MUL: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in  = 1'b0;
               tmp_in   = alu_rsp.result;
               state_in = S_ANG_DIV;
            end
         end
         S_ANG_DIV: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in     = 1'b0;
               tx_in       = HALFPI_Q - h_ff + alu_rsp.result[30:0];
               cos_mode_in = 1'b1;
               ret_in      = S_COS_DONE;
               state_in    = S_TRIG_SQ;
            end
         end
         S_COS_DONE: begin
            cval_in     = sum_ff;
            cos_mode_in = 1'b0;
            ret_in      = S_SC_X;
            state_in    = S_TRIG_SQ;
         end

         // scale by |r| with rounding half away from zero
         S_SC_X: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in  = 1'b0;
               xval_in  = cval_ff[35] ? -$signed({2'b0, p_w}) : $signed({2'b0, p_w});
               state_in = S_SC_Z;
            end
         end
         S_SC_Z: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in          = 1'b0;
               pt_in.point_x    = sat25(xval_ff);
               pt_in.point_z    = sat25(z_w);
               pt_in.is_plane   = 1'b0;
               pt_in.last_point = ((i_ff + 6'd1) == half_ff);
               state_in         = S_EMIT;
            end
         end

         // hand the point over
         S_EMIT: begin
            if (pt_ready) begin
               if (pt_ff.last_point) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 6'd1;
                  state_in = plane_ff ? S_PL_MUL : S_ANG_MUL;
               end
            end
         end

         // taylor series: square, then term = term*x2 >> 30 / divisor
         S_TRIG_SQ: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in  = 1'b0;
               x2_in    = rnd_w[61:30];
               term_in  = cos_mode_ff ? {1'b0, ONE_Q} : {1'b0, tx_ff};
               sum_in   = cos_mode_ff ? $signed({5'd0, ONE_Q}) : $signed({5'd0, tx_ff});
               k_in     = 4'd1;
               state_in = S_TRIG_MUL;
            end
         end
         S_TRIG_MUL: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in  = 1'b0;
               tmp_in   = {30'd0, alu_rsp.result[63:30]};
               state_in = S_TRIG_DIV;
            end
         end
         S_TRIG_DIV: begin
            if (wait_ff && alu_rsp.done) begin
               wait_in = 1'b0;
               term_in = alu_rsp.result[31:0];
               sum_in  = k_ff[0] ? (sum_ff - q_signed_w) : (sum_ff + q_signed_w);
               if (k_ff == k_last_w) begin
                  state_in = ret_ff;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = S_TRIG_MUL;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign idle     = (state_ff == S_IDLE);
   assign pt       = pt_ff;
   assign pt_valid = (state_ff == S_EMIT);

endmodule
`default_nettype wire

// File: rtl/core/lens_profile_point_generator_unit.sv
// top level: register port, request intake, sequencer and result register
//
// Lens profile point generator. A request (req_diameter, req_radius) yields
// a run of profile points on the rsp channel, rim first, the final point
// marked by rsp_last_point. A flat surface (radius zero or 2|r| < d) gives
// stack_count/2+1 points with z = 0; a curved one gives stack_count/2 points.
// All arithmetic runs through one bit-serial unit. A flat point needs one
// multiply and one divide. A curved surface first spends one divide plus up
// to 31 taylor sin evaluations on the asin search, then per point an angle
// multiply and divide, one cos, one sin and two scaling multiplies.
// One request is worked on at a time; req_ready is high only while the
// sequencer is idle. The result register holds a point until rsp_ready;
// while it stalls the sequencer waits with the next point. After the last
// point is in the result register a new request can be accepted.
// Reset (synchronous) empties the result register, returns the sequencer
// to idle and sets stack_count to 32. stack_count sits at address 0 and
// should be written only while the block is idle.
`default_nettype none
module lens_profile_point_generator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [23:0] req_diameter,
   input  wire logic [23:0] req_radius,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [24:0]      rsp_point_x,
   output logic [24:0]      rsp_point_z,
   output logic             rsp_is_plane,
   output logic             rsp_last_point,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import lppg_pkg::*;

   logic [6:0]  stack_count_ff, stack_count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   point_type   rsp_ff, rsp_in;

   logic        seq_idle;
   logic        pt_valid;
   logic        pt_ready;
   point_type   pt;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   logic        csr_wr;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign prdata = (paddr[2] == 1'b0) ? {25'd0, stack_count_ff} : 32'd0;
   assign stack_count_in = csr_wr ? pwdata[6:0] : stack_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= 7'd32;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stack_count_ff <= stack_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // result register
   assign pt_ready = !rsp_valid_ff || rsp_ready;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pt_ready) begin
         rsp_valid_in = pt_valid;
         if (pt_valid) rsp_in = pt;
      end
   end

   assign req_ready      = seq_idle;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_ff.point_x;
   assign rsp_point_z    = rsp_ff.point_z;
   assign rsp_is_plane   = rsp_ff.is_plane;
   assign rsp_last_point = rsp_ff.last_point;

   lppg_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_valid && seq_idle),
      .diameter    (req_diameter),
      .radius      (req_radius),
      .stack_count (stack_count_ff),
      .idle        (seq_idle),
      .alu_req     (alu_req),
      .alu_rsp     (alu_rsp),
      .pt          (pt),
      .pt_valid    (pt_valid),
      .pt_ready    (pt_ready)
   );

   lppg_serial_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

endmodule
`default_nettype wire

// File: rtl/core/lppg_checker.sv
// port-level checker for the lens profile point generator and its bind
`default_nettype none
module lppg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [24:0] rsp_point_x,
   input wire logic [24:0] rsp_point_z,
   input wire logic        rsp_is_plane,
   input wire logic        rsp_last_point
);

   // a stalled point holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_z))
      else $error("stalled point changed");

   // flat points lie on z = 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_plane |-> rsp_point_z == 25'd0)
      else $error("flat point with nonzero z");

   // an accepted request keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lens_profile_point_generator_unit lppg_checker u_lppg_checker (.*);
`default_nettype wire

// File: tb/sv/lens_profile_point_generator_unit_test.sv
// testbench of the lens profile point generator: directed and random requests, scoreboard
`timescale 1ns / 1ps
module lens_profile_point_generator_unit_test;
   import lppg_pkg::*;

   localparam logic [2:0] ADDR_STACK_COUNT = 3'd0;
   localparam logic [2:0] ADDR_UNUSED = 3'd4;
   localparam longint QUIET_LIMIT = 200000;
   localparam int HOLD_CYCLES = 2500;
   localparam longint OUT_MAX = 64'sd16777215;
   localparam longint OUT_MIN = -64'sd16777216;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [23:0] req_diameter = '0;
   logic [23:0] req_radius = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [24:0] rsp_point_x;
   logic [24:0] rsp_point_z;
   logic rsp_is_plane;
   logic rsp_last_point;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // predicted profile points, oldest first
   point_type expected_points[$];
   logic [6:0] stack_count_model = 7'd32;
   int error_count = 0;
   int point_count = 0;
   int flat_requests = 0;
   int curved_requests = 0;
   int burst_left = 0;
   logic hold_off = 1'b0;
   longint quiet_cycles = 0;

   lens_profile_point_generator_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_diameter(req_diameter), .req_radius(req_radius),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_point_x(rsp_point_x), .rsp_point_z(rsp_point_z),
      .rsp_is_plane(rsp_is_plane), .rsp_last_point(rsp_last_point),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // q30 square, rounded
   function automatic longint unsigned q30_square(input longint unsigned x);
      return (x * x + 64'h2000_0000) >> 30;
   endfunction

   function automatic longint sin_series(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      x2 = q30_square(x);
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum -= longint'(term); else sum += longint'(term);
      end
      return sum;
   endfunction

   function automatic longint cos_series(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      x2 = q30_square(x);
      term = 64'h4000_0000;
      sum = 64'sh4000_0000;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) sum -= longint'(term); else sum += longint'(term);
      end
      return sum;
   endfunction

   // magnitude times q30 value, rounded half away from zero
   function automatic longint scale_radius(input longint unsigned m, input longint t);
      longint unsigned mag;
      longint p;
      mag = (t < 0) ? longint'(-t) : longint'(t);
      p = longint'((m * mag + 64'h2000_0000) >> 30);
      return (t < 0) ? -p : p;
   endfunction

   function automatic logic [24:0] clamp_coord(input longint v);
      if (v > OUT_MAX) v = OUT_MAX;
      if (v < OUT_MIN) v = OUT_MIN;
      return v[24:0];
   endfunction

   // work out every point a request yields and queue it
   function automatic void predict_profile(input logic [23:0] dia, input logic [23:0] rad);
      longint unsigned d;
      longint r;
      longint unsigned rabs;
      longint unsigned stacks;
      longint unsigned half;
      longint unsigned s;
      longint unsigned h;
      longint unsigned cand;
      longint unsigned a;
      longint z;
      point_type p;
      d = dia;
      r = {{40{rad[23]}}, rad};
      rabs = (r < 0) ? longint'(-r) : longint'(r);
      stacks = (stack_count_model < 2) ? 2 : stack_count_model;
      half = stacks / 2;
      if (r == 0 || 4 * rabs * rabs < d * d) begin
         flat_requests++;
         for (longint unsigned i = 0; i <= half; i++) begin
            p.point_x = clamp_coord(longint'((d * (stacks - 2 * i) + stacks) / (2 * stacks)));
            p.point_z = '0;
            p.is_plane = 1'b1;
            p.last_point = (i == half);
            expected_points = {expected_points, p};
         end
      end else begin
         curved_requests++;
         s = (d << 30) / (2 * rabs);
         if (s > 64'h4000_0000) s = 64'h4000_0000;
         // bitwise asin search
         h = 0;
         for (int b = 30; b >= 0; b--) begin
            cand = h | (64'd1 << b);
            if (cand <= longint'(HALFPI_Q) && sin_series(cand) <= longint'(s)) h = cand;
         end
         for (longint unsigned i = 0; i < half; i++) begin
            a = longint'(HALFPI_Q) - h + ((i + 1) * h) / half;
            z = scale_radius(rabs, sin_series(a)) - longint'(rabs);
            if (r < 0) z = -z;
            p.point_x = clamp_coord(scale_radius(rabs, cos_series(a)));
            p.point_z = clamp_coord(z);
            p.is_plane = 1'b0;
            p.last_point = (i + 1 == half);
            expected_points = {expected_points, p};
         end
      end
   endfunction

   // register write: setup cycle then access cycle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_STACK_COUNT) stack_count_model = data[6:0];
   endtask

   // wait for every point, then let the sequencer settle
   task automatic wait_idle();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   // offer one request, with bursts and gaps between them
   task automatic send_request(input logic [23:0] dia, input logic [23:0] rad);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_diameter <= dia;
      req_radius <= rad;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_profile(dia, rad);
   endtask

   task automatic end_requests();
      req_valid <= 1'b0;
      burst_left = 0;
   endtask

   // random curved request: nonzero radius, diameter up to twice its size
   task automatic send_random_curved();
      logic [23:0] rad;
      longint unsigned rabs;
      rad = 24'($urandom());
      if (rad == 0) rad = 24'd1;
      rabs = rad[23] ? longint'(-longint'({{40{1'b1}}, rad})) : longint'(rad);
      send_request(24'(longint'($urandom()) % (2 * rabs + 1)), rad);
   endtask

   // random flat request: zero radius or 2|r| below the diameter
   task automatic send_random_flat();
      logic [23:0] dia;
      logic [23:0] rad;
      dia = 24'($urandom());
      if ($urandom_range(0, 3) == 0 || dia < 2) rad = '0;
      else begin
         rad = 24'($urandom_range(1, (dia - 1) / 2));
         if ($urandom_range(0, 1) == 1) rad = -rad;
      end
      send_request(dia, rad);
   endtask

   task automatic test_flat_extremes();
      send_request(24'd0, 24'd0);
      send_request(24'hFF_FFFF, 24'd0);
      send_request(24'hFF_FFFF, 24'h7F_FFFF);
      send_request(24'hFF_FFFF, 24'h80_0001);
      send_request(24'd3, 24'd1);
      send_request(24'h12_3457, 24'hF6_E5D4);
      end_requests();
      wait_idle();
   endtask

   task automatic test_curved_extremes();
      send_request(24'd0, 24'd1);
      send_request(24'hFF_FFFF, 24'h80_0000);
      send_request(24'd2, 24'd1);
      send_request(24'h02_0000, 24'hFF_0000);
      send_request(24'h00_8000, 24'h7F_FFFF);
      send_request(24'h55_5555, 24'h40_0000);
      end_requests();
      wait_idle();
   endtask

   // stack counts at and beyond the ends, odd counts, masked and misplaced writes
   task automatic test_stack_counts();
      csr_write(ADDR_STACK_COUNT, 32'd0);
      send_request(24'h10_0000, 24'd0);
      send_request(24'h10_0000, 24'h10_0000);
      end_requests();
      wait_idle();
      csr_write(ADDR_STACK_COUNT, 32'd1);
      send_request(24'h0F_0000, 24'h00_4000);
      send_request(24'h0F_0000, 24'hF8_0000);
      end_requests();
      wait_idle();
      csr_write(ADDR_STACK_COUNT, 32'hFFFF_FF83);
      send_request(24'hAB_CDEF, 24'd0);
      send_request(24'h01_0000, 24'h01_0000);
      end_requests();
      wait_idle();
      csr_write(ADDR_STACK_COUNT, 32'd127);
      csr_write(ADDR_UNUSED, 32'd4);
      send_request(24'hFF_FFFF, 24'd0);
      send_request(24'h00_0001, 24'h7F_FFFF);
      end_requests();
      wait_idle();
      csr_write(ADDR_STACK_COUNT, 32'd126);
      send_request(24'hC0_0000, 24'h00_1000);
      end_requests();
      wait_idle();
   endtask

   // mostly flat surfaces, a quarter curved, small stack counts keep it quick
   task automatic test_random(input int count, input logic [6:0] stacks);
      csr_write(ADDR_STACK_COUNT, {25'd0, stacks});
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) send_random_curved();
         else send_random_flat();
      end
      end_requests();
      wait_idle();
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      csr_write(ADDR_STACK_COUNT, 32'd8);
      hold_off = 1'b1;
      for (int n = 0; n < 12; n++) send_random_flat();
      end_requests();
      wait_idle();
   endtask

   // result checker and receiver stall pattern
   initial begin : result_side
      int hold_left;
      int mode_left;
      int mode;
      point_type want;
      hold_left = 0;
      mode_left = 0;
      mode = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            point_count++;
            if (expected_points.size() == 0) begin
               error_count++;
               $display("%0t: unexpected point x=%0h z=%0h", $time, rsp_point_x, rsp_point_z);
            end else begin
               want = expected_points.pop_front();
               if (rsp_point_x !== want.point_x) begin
                  error_count++;
                  $display("%0t: point_x expected %0h actual %0h", $time, want.point_x,
                           rsp_point_x);
               end
               if (rsp_point_z !== want.point_z) begin
                  error_count++;
                  $display("%0t: point_z expected %0h actual %0h", $time, want.point_z,
                           rsp_point_z);
               end
               if (rsp_is_plane !== want.is_plane) begin
                  error_count++;
                  $display("%0t: is_plane expected %0b actual %0b", $time, want.is_plane,
                           rsp_is_plane);
               end
               if (rsp_last_point !== want.last_point) begin
                  error_count++;
                  $display("%0t: last_point expected %0b actual %0b", $time, want.last_point,
                           rsp_last_point);
               end
            end
         end
         if (hold_off) begin
            hold_off = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (mode == 0) rsp_ready <= 1'b1;
         else if (mode == 1) rsp_ready <= ($urandom_range(0, 1) == 1);
         else rsp_ready <= ($urandom_range(0, 7) != 0);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress, %0d points outstanding", $time, expected_points.size());
         $display("FAIL lens_profile_point_generator_unit");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (8) @(posedge clock);
      test_flat_extremes();
      test_curved_extremes();
      test_stack_counts();
      test_backpressure();
      test_random(240, 7'd6);
      test_random(20, 7'd3);
      test_random(10, 7'd20);
      $display("covered %0d flat and %0d curved surfaces, %0d points checked",
               flat_requests, curved_requests, point_count);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("PASS lens_profile_point_generator_unit");
      end else begin
         $display("%0d errors, %0d points missing", error_count, expected_points.size());
         $display("FAIL lens_profile_point_generator_unit");
      end
      $finish;
   end
endmodule

// File: files.f
rtl/core/lppg_pkg.sv
rtl/core/lppg_serial_alu.sv
rtl/core/lppg_seq.sv
rtl/core/lens_profile_point_generator_unit.sv
rtl/core/lppg_checker.sv
tb/sv/lens_profile_point_generator_unit_test.sv
